>>> rtl/skt_pkg.sv
// Shared types and constants for the sorted key table lookup block.
// Used by skt_ctrl, skt_datapath and sorted_key_table_lookup_core.
`default_nettype none

package skt_pkg;

    localparam int KEY_W    = 29;
    localparam int CODE_W   = 8;
    localparam int STATUS_W = 2;

    // Request types
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CMP,
        S_SHIFT_START,
        S_SHIFT,
        S_WRITE_NEW,
        S_RESULT
    } state_t;

    // Read address source for the table memory
    typedef enum logic [1:0] {
        RD_MID,
        RD_MID_NEXT,
        RD_PTR1,
        RD_PTR2
    } rd_sel_t;

    typedef enum logic [1:0] {
        RES_DONE,
        RES_FOUND,
        RES_MISS,
        RES_FULL
    } res_kind_t;

    typedef struct packed {
        logic      load;       // latch request, open search window
        logic      rd_en;      // table read, data registered
        rd_sel_t   rd_sel;
        logic      bound_upd;  // narrow the search window
        logic      shift_wr;   // move one entry up and step the pointer down
        logic      new_wr;     // write the new pair, bump the count
        logic      res_set;
        res_kind_t res_kind;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic is_lookup;
        logic full;
        logic open;        // low < high
        logic next_open;   // window after this compare still non-empty
        logic key_eq;
        logic ptr_above;   // ptr > insert position
        logic ptr1_above;  // ptr - 1 > insert position
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> rtl/skt_ctrl.sv
// Controller state machine for the sorted key table lookup block.
// Depends on skt_pkg; drives skt_datapath through cmd_t, reads sts_t.
`default_nettype none

module skt_ctrl
    import skt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel   = RD_MID;
        cmd.res_kind = RES_DONE;
        in_ready   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (!sts.is_lookup && sts.full) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_kind = RES_FULL;
                    state_next   = S_RESULT;
                end else if (sts.open) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_MID;
                    state_next = S_CMP;
                end else if (sts.is_lookup) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_kind = RES_MISS;
                    state_next   = S_RESULT;
                end else begin
                    state_next = S_SHIFT_START;
                end
            end

            S_CMP:
            begin
                cmd.bound_upd = 1'b1;
                if (sts.is_lookup && sts.key_eq) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_kind = RES_FOUND;
                    state_next   = S_RESULT;
                end else if (sts.next_open) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_MID_NEXT;
                end else if (sts.is_lookup) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_kind = RES_MISS;
                    state_next   = S_RESULT;
                end else begin
                    state_next = S_SHIFT_START;
                end
            end

            S_SHIFT_START:
            begin
                if (sts.ptr_above) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PTR1;
                    state_next = S_SHIFT;
                end else begin
                    state_next = S_WRITE_NEW;
                end
            end

            S_SHIFT:
            begin
                cmd.shift_wr = 1'b1;
                if (sts.ptr1_above) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PTR2;
                end else begin
                    state_next = S_WRITE_NEW;
                end
            end

            S_WRITE_NEW:
            begin
                cmd.new_wr   = 1'b1;
                cmd.res_set  = 1'b1;
                cmd.res_kind = RES_DONE;
                state_next   = S_RESULT;
            end

            S_RESULT:
            begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/skt_datapath.sv
// Datapath of the sorted key table: table memory, search window, shift
// pointer, entry count, config register and output register. Uses skt_pkg.
`default_nettype none

module skt_datapath
    import skt_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    output sts_t                     sts,
    input  wire logic                req_type,
    input  wire logic [KEY_W-1:0]    key,
    input  wire logic [CODE_W-1:0]   code,
    input  wire logic                cfg_wr,
    input  wire logic [CODE_W-1:0]   cfg_unknown_code,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic [CODE_W-1:0]        result_code
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [KEY_W-1:0]  key_mem  [TABLE_DEPTH];
    logic [CODE_W-1:0] code_mem [TABLE_DEPTH];

    logic                req_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [CNT_W-1:0]    low_reg;
    logic [CNT_W-1:0]    high_reg;
    logic [CNT_W-1:0]    ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [KEY_W-1:0]    rd_key_reg;
    logic [CODE_W-1:0]   rd_code_reg;
    logic [CODE_W-1:0]   unknown_code_reg;
    res_kind_t           res_kind_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [CODE_W-1:0]   result_code_reg;

    logic [CNT_W:0]      sum_cur;
    logic [CNT_W-1:0]    mid_cur;
    logic [CNT_W-1:0]    low_next;
    logic [CNT_W-1:0]    high_next;
    logic [CNT_W:0]      sum_nxt;
    logic [CNT_W-1:0]    mid_nxt;
    logic [CNT_W-1:0]    ptr_m1;
    logic [CNT_W-1:0]    ptr_m2;
    logic                key_lt;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [KEY_W-1:0]    wr_key;
    logic [CODE_W-1:0]   wr_code;

    // Search window arithmetic
    assign sum_cur   = {1'b0, low_reg} + {1'b0, high_reg};
    assign mid_cur   = sum_cur[CNT_W:1];
    assign key_lt    = key_reg < rd_key_reg;
    assign low_next  = key_lt ? low_reg : mid_cur + CNT_W'(1);
    assign high_next = key_lt ? mid_cur : high_reg;
    assign sum_nxt   = {1'b0, low_next} + {1'b0, high_next};
    assign mid_nxt   = sum_nxt[CNT_W:1];

    assign ptr_m1 = ptr_reg - CNT_W'(1);
    assign ptr_m2 = ptr_reg - CNT_W'(2);

    always_comb begin
        case (cmd.rd_sel)
            RD_MID:      rd_addr = mid_cur[IDX_W-1:0];
            RD_MID_NEXT: rd_addr = mid_nxt[IDX_W-1:0];
            RD_PTR1:     rd_addr = ptr_m1[IDX_W-1:0];
            RD_PTR2:     rd_addr = ptr_m2[IDX_W-1:0];
            default:     rd_addr = mid_cur[IDX_W-1:0];
        endcase
    end

    assign wr_en   = cmd.shift_wr | cmd.new_wr;
    assign wr_addr = cmd.shift_wr ? ptr_reg[IDX_W-1:0] : low_reg[IDX_W-1:0];
    assign wr_key  = cmd.shift_wr ? rd_key_reg : key_reg;
    assign wr_code = cmd.shift_wr ? rd_code_reg : code_reg;

    // Table memory: one write, one registered read per cycle
    always_ff @(posedge clk) begin
        if (wr_en) begin
            key_mem[wr_addr]  <= wr_key;
            code_mem[wr_addr] <= wr_code;
        end
        if (cmd.rd_en) begin
            rd_key_reg  <= key_mem[rd_addr];
            rd_code_reg <= code_mem[rd_addr];
        end
    end

    // Request, window and pointer registers
    always_ff @(posedge clk) begin
        if (cmd.load) begin
            req_reg  <= req_type;
            key_reg  <= key;
            code_reg <= code;
            low_reg  <= '0;
            high_reg <= count_reg;
            ptr_reg  <= count_reg;
        end else begin
            if (cmd.bound_upd) begin
                low_reg  <= low_next;
                high_reg <= high_next;
            end
            if (cmd.shift_wr) begin
                ptr_reg <= ptr_m1;
            end
        end
        if (cmd.res_set) begin
            res_kind_reg <= cmd.res_kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            count_reg        <= '0;
            unknown_code_reg <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cmd.new_wr) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cfg_wr) begin
                unknown_code_reg <= cfg_unknown_code;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge clk) begin
        if (cmd.out_load) begin
            case (res_kind_reg)
                RES_DONE:
                begin
                    status_reg      <= ST_OK;
                    result_code_reg <= '0;
                end
                RES_FOUND:
                begin
                    status_reg      <= ST_OK;
                    result_code_reg <= rd_code_reg;
                end
                RES_MISS:
                begin
                    status_reg      <= ST_MISS;
                    result_code_reg <= unknown_code_reg;
                end
                default:
                begin
                    status_reg      <= ST_FULL;
                    result_code_reg <= '0;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign result_code = result_code_reg;

    always_comb begin
        sts.is_lookup  = req_reg == REQ_LOOKUP;
        sts.full       = count_reg == CNT_W'(TABLE_DEPTH);
        sts.open       = low_reg < high_reg;
        sts.next_open  = low_next < high_next;
        sts.key_eq     = key_reg == rd_key_reg;
        sts.ptr_above  = ptr_reg != low_reg;
        sts.ptr1_above = ptr_m1 != low_reg;
        sts.out_free   = !out_valid_reg || out_ready;
    end

endmodule

`default_nettype wire

>>> rtl/sorted_key_table_lookup_core.sv
// Top level of the sorted key table lookup block.
// Depends on skt_pkg, skt_ctrl and skt_datapath.
//
//   channel   signals                                   direction
//   -------   ---------------------------------------   ---------
//   in        in_valid/in_ready, req_type, key, code     request in
//   out       out_valid/out_ready, status, result_code   result out
//   cfg       cfg_valid/cfg_ready, cfg_unknown_code      register write
//
// One request at a time. A lookup makes at most floor(log2(entry_count)) + 1
// binary-search probes; the table memory has one registered read port, so the
// probes are made one after another.
// An insert makes the same search, and then the entries above
// the insert position move up one per cycle through the same read port and
// the write port. A refused insert on a full table skips the search.
// Reset clears the entry count, the unknown code and the output valid; the
// table memory is not cleared. A stalled output holds the result, and a new
// request is still accepted while it waits; that request finishes when the
// output register frees. cfg_ready is always high.
`default_nettype none

module sorted_key_table_lookup_core
    import skt_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                req_type,
    input  wire logic [KEY_W-1:0]    key,
    input  wire logic [CODE_W-1:0]   code,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic [CODE_W-1:0]        result_code,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CODE_W-1:0]   cfg_unknown_code
);

    cmd_t cmd;
    sts_t sts;
    logic cfg_wr;

    // Config writes are always accepted; cfg_ready is tied high
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    skt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    skt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .req_type         (req_type),
        .key              (key),
        .code             (code),
        .cfg_wr           (cfg_wr),
        .cfg_unknown_code (cfg_unknown_code),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .result_code      (result_code)
    );

endmodule

`default_nettype wire

>>> test/sorted_key_table_lookup_core_tb.sv
// Self-checking testbench for sorted_key_table_lookup_core: insert and lookup requests.
// Results are checked against a sorted-table predictor kept in the bench.
// Depends on skt_pkg and the RTL of sorted_key_table_lookup_core.

module sorted_key_table_lookup_core_tb;
    import skt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 256;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 215;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    typedef struct packed {
        logic [STATUS_W-1:0] st;
        logic [CODE_W-1:0]   rc;
    } result_t;

    typedef struct packed {
        logic              rt;
        logic [KEY_W-1:0]  k;
        logic [CODE_W-1:0] c;
        logic              chk;
        result_t           want;
    } dir_row_t;

    logic                clk              = 1'b0;
    logic                rst_n            = 1'b0;
    logic                in_valid         = 1'b0;
    logic                in_ready;
    logic                req_type         = REQ_INSERT;
    logic [KEY_W-1:0]    key              = '0;
    logic [CODE_W-1:0]   code             = '0;
    logic                out_valid;
    logic                out_ready        = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [CODE_W-1:0]   result_code;
    logic                cfg_valid        = 1'b0;
    logic                cfg_ready;
    logic [CODE_W-1:0]   cfg_unknown_code = '0;

    // Predictor state: the sorted pairs, the fill level and the unknown code.
    logic [KEY_W-1:0]    stored_keys [DEPTH];
    logic [CODE_W-1:0]   stored_codes[DEPTH];
    int                  stored_count     = 0;
    logic [CODE_W-1:0]   unknown_code_q   = '0;

    result_t             pending_results[$];
    dir_row_t            directed_rows[$];
    result_t             want;
    int                  mismatch_count   = 0;
    int unsigned         cycle_count      = 0;
    int                  sender_idle_pct  = 0;
    int                  recv_stall_pct   = 0;

    sorted_key_table_lookup_core #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .key              (key),
        .code             (code),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .result_code      (result_code),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_unknown_code (cfg_unknown_code)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one request to the predictor and return the result it must give.
    // Insert: place the pair before the first strictly greater key, so equal
    // keys go after the ones already held; refuse when the table is full.
    // Lookup: binary search over [lo, hi) probing floor((lo + hi) / 2).
    function automatic result_t table_access(input logic rt, input logic [KEY_W-1:0] k,
                                             input logic [CODE_W-1:0] c);
        result_t r;
        int      pos;
        int      lo;
        int      hi;
        int      mid;
        bit      hit;
        r.st = ST_OK;
        r.rc = '0;
        if (rt == REQ_INSERT)
        begin
            if (stored_count >= DEPTH)
                r.st = ST_FULL;
            else
            begin
                pos = stored_count;
                for (int i = 0; i < stored_count; i++)
                    if (pos == stored_count && stored_keys[i] > k)
                        pos = i;
                for (int i = stored_count; i > pos; i--)
                begin
                    stored_keys[i]  = stored_keys[i-1];
                    stored_codes[i] = stored_codes[i-1];
                end
                stored_keys[pos]  = k;
                stored_codes[pos] = c;
                stored_count++;
            end
        end
        else
        begin
            lo  = 0;
            hi  = stored_count;
            hit = 1'b0;
            while (lo < hi && !hit)
            begin
                mid = (lo + hi) >> 1;
                if (k < stored_keys[mid])
                    hi = mid;
                else if (k > stored_keys[mid])
                    lo = mid + 1;
                else
                begin
                    hit  = 1'b1;
                    r.rc = stored_codes[mid];
                end
            end
            if (!hit)
            begin
                r.st = ST_MISS;
                r.rc = unknown_code_q;
            end
        end
        return r;
    endfunction

    // Offer one request, idling first as the sender mode asks. Valid stays up
    // from one request to the next when no idle cycle falls between them.
    // On accept, run the predictor; push the typed result instead when given.
    task automatic send_request(input logic rt, input logic [KEY_W-1:0] k,
                                input logic [CODE_W-1:0] c, input logic chk,
                                input result_t typed);
        result_t r;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        key      <= k;
        code     <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = table_access(rt, k, c);
        pending_results.push_back(chk ? typed : r);
    endtask

    // Write the unknown code; only called with nothing in flight.
    task automatic write_unknown_code(input logic [CODE_W-1:0] v);
        cfg_valid        <= 1'b1;
        cfg_unknown_code <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        unknown_code_q = v;
        cfg_valid <= 1'b0;
    endtask

    // Hold off new requests until every expected result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(input logic rt, input logic [KEY_W-1:0] k,
                           input logic [CODE_W-1:0] c, input logic chk,
                           input logic [STATUS_W-1:0] st, input logic [CODE_W-1:0] rc);
        dir_row_t row;
        row.rt      = rt;
        row.k       = k;
        row.c       = c;
        row.chk     = chk;
        row.want.st = st;
        row.want.rc = rc;
        directed_rows.push_back(row);
    endtask

    // Receiver: stall at random per cycle, as the current phase asks.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Result checker: compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, got status %0d code 0x%02h",
                         $time, status, result_code);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st)
                begin
                    mismatch_count++;
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.st, status);
                end
                if (result_code !== want.rc)
                begin
                    mismatch_count++;
                    $display("%0t: result_code mismatch, expected 0x%02h, got 0x%02h",
                             $time, want.rc, result_code);
                end
            end
        end
    end

    // Watchdog: end the run as failed once cycle_count reaches CYCLE_LIMIT.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        logic              rt;
        logic [KEY_W-1:0]  k;
        logic [CODE_W-1:0] c;
        int                pick;
        result_t           no_typed;
        no_typed = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty-table misses, extreme keys and codes, duplicate
        // keys (the lookup answers whichever equal entry it probes first) and
        // a code field that a lookup must ignore. Run with no idling.
        write_unknown_code(8'hFF);
        add_row(REQ_LOOKUP, '0,             8'hAB, 1'b1, ST_MISS, 8'hFF);
        add_row(REQ_LOOKUP, KEY_MAX,        8'h00, 1'b1, ST_MISS, 8'hFF);
        add_row(REQ_INSERT, '0,             8'h00, 1'b1, ST_OK,   8'h00);
        add_row(REQ_INSERT, KEY_MAX,        8'hFF, 1'b1, ST_OK,   8'h00);
        add_row(REQ_INSERT, 29'd1000,       8'h5A, 1'b1, ST_OK,   8'h00);
        add_row(REQ_LOOKUP, '0,             8'hFF, 1'b1, ST_OK,   8'h00);
        add_row(REQ_LOOKUP, KEY_MAX,        8'h00, 1'b1, ST_OK,   8'hFF);
        add_row(REQ_LOOKUP, 29'd1000,       8'h11, 1'b1, ST_OK,   8'h5A);
        add_row(REQ_LOOKUP, 29'd999,        8'h00, 1'b1, ST_MISS, 8'hFF);
        add_row(REQ_INSERT, 29'd1000,       8'h3C, 1'b1, ST_OK,   8'h00);
        add_row(REQ_LOOKUP, 29'd1000,       8'h00, 1'b0, ST_OK,   8'h00);
        add_row(REQ_INSERT, 29'd1000,       8'h77, 1'b1, ST_OK,   8'h00);
        add_row(REQ_LOOKUP, 29'd1000,       8'hFF, 1'b0, ST_OK,   8'h00);
        add_row(REQ_INSERT, KEY_MAX,        8'h01, 1'b1, ST_OK,   8'h00);
        add_row(REQ_LOOKUP, KEY_MAX,        8'h00, 1'b0, ST_OK,   8'h00);
        add_row(REQ_INSERT, '0,             8'h80, 1'b1, ST_OK,   8'h00);
        add_row(REQ_LOOKUP, '0,             8'h00, 1'b0, ST_OK,   8'h00);
        add_row(REQ_INSERT, 29'h0AAA_AAAA,  8'hAA, 1'b1, ST_OK,   8'h00);
        add_row(REQ_INSERT, 29'h1555_5555,  8'h55, 1'b1, ST_OK,   8'h00);
        add_row(REQ_LOOKUP, 29'h0AAA_AAAA,  8'h00, 1'b1, ST_OK,   8'hAA);
        add_row(REQ_LOOKUP, 29'h1555_5555,  8'h00, 1'b1, ST_OK,   8'h55);
        add_row(REQ_LOOKUP, 29'd1,          8'h00, 1'b1, ST_MISS, 8'hFF);
        foreach (directed_rows[i])
            send_request(directed_rows[i].rt, directed_rows[i].k, directed_rows[i].c,
                         directed_rows[i].chk, directed_rows[i].want);

        // Random part. Each phase starts from an idle block (the sender waits
        // for every result before the register write) and picks an idling mode.
        // About a quarter of the requests insert, so the table fills partway
        // through and later inserts get refused as full.
        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            case (p)
                0:       write_unknown_code(8'h00);
                1:       write_unknown_code(8'hFF);
                default: write_unknown_code(CODE_W'($urandom_range(255)));
            endcase
            case (p % 4)
                0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin sender_idle_pct = 58; recv_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin sender_idle_pct = 8;  recv_stall_pct = 8;  end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                rt   = ($urandom_range(99) < 25) ? REQ_INSERT : REQ_LOOKUP;
                c    = CODE_W'($urandom);
                k    = KEY_W'($urandom);
                pick = $urandom_range(99);
                if (rt == REQ_LOOKUP)
                begin
                    // Mostly hit stored keys; probe neighbors and extremes too.
                    if (stored_count > 0 && pick < 55)
                        k = stored_keys[$urandom_range(stored_count - 1)];
                    else if (stored_count > 0 && pick < 70)
                        k = stored_keys[$urandom_range(stored_count - 1)]
                            + (pick[0] ? KEY_W'(1) : {KEY_W{1'b1}});
                    else if (pick < 75)
                        k = pick[0] ? KEY_MAX : '0;
                end
                else
                begin
                    // Reuse stored keys now and then to build duplicate runs.
                    if (stored_count > 0 && pick < 20)
                        k = stored_keys[$urandom_range(stored_count - 1)];
                    else if (pick < 25)
                        k = pick[0] ? KEY_MAX : '0;
                end
                send_request(rt, k, c, 1'b0, no_typed);
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sorted_key_table_lookup_core.f
rtl/skt_pkg.sv
rtl/skt_ctrl.sv
rtl/skt_datapath.sv
rtl/sorted_key_table_lookup_core.sv
test/sorted_key_table_lookup_core_tb.sv
